/* rtl/rgb555_mipmap_box_downsample_core_assert.svh */
// Assertion macros shared by the mip level downsampler RTL.
`ifndef RGB555_MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH
`define RGB555_MIPMAP_BOX_DOWNSAMPLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RGBMIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgbmip assertion failed");
`define RGBMIP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rgbmip assertion failed");
`else
`define RGBMIP_ASSERT(label, prop)
`define RGBMIP_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* rtl/rgbmip_pkg.sv */
// Package with constants and channel arithmetic for the mip level downsampler.
package rgbmip_pkg;

  localparam int CH_W         = 5;
  localparam int PAIR_CH_W    = CH_W + 1;
  localparam int PIXEL_W      = 3 * CH_W;
  localparam int LINE_W       = 3 * PAIR_CH_W;
  localparam int SRC_DATA_W   = 16;
  localparam int OUT_SIDE_W   = 9;
  localparam int DEFAULT_MAX_OUT_SIDE = 256;
  localparam logic [OUT_SIDE_W-1:0] OUT_SIDE_RESET = 9'd256;

  // Sum the three channels of two pixels pairwise; red ends up in the top field.
  function automatic logic [LINE_W-1:0] pair_sum(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
    logic [PAIR_CH_W-1:0] r;
    logic [PAIR_CH_W-1:0] g;
    logic [PAIR_CH_W-1:0] bl;
    r  = PAIR_CH_W'(a[3*CH_W-1:2*CH_W]) + PAIR_CH_W'(b[3*CH_W-1:2*CH_W]);
    g  = PAIR_CH_W'(a[2*CH_W-1:CH_W])   + PAIR_CH_W'(b[2*CH_W-1:CH_W]);
    bl = PAIR_CH_W'(a[CH_W-1:0])        + PAIR_CH_W'(b[CH_W-1:0]);
    return {r, g, bl};
  endfunction

  // Rounded mean of four values given as two pair sums.
  function automatic logic [CH_W-1:0] avg_channel(input logic [PAIR_CH_W-1:0] top,
                                                   input logic [PAIR_CH_W-1:0] bot);
    logic [PAIR_CH_W+1:0] s;
    s = (PAIR_CH_W+2)'(top) + (PAIR_CH_W+2)'(bot) + (PAIR_CH_W+2)'(2);
    return s[CH_W+1:2];
  endfunction

  function automatic logic [PIXEL_W-1:0] avg_pixel(input logic [LINE_W-1:0] top,
                                                   input logic [LINE_W-1:0] bot);
    return {avg_channel(top[3*PAIR_CH_W-1:2*PAIR_CH_W], bot[3*PAIR_CH_W-1:2*PAIR_CH_W]),
            avg_channel(top[2*PAIR_CH_W-1:PAIR_CH_W],   bot[2*PAIR_CH_W-1:PAIR_CH_W]),
            avg_channel(top[PAIR_CH_W-1:0],             bot[PAIR_CH_W-1:0])};
  endfunction

endpackage

/* rtl/rgbmip_ram.sv */
// Simple dual-port RAM with registered, write-first read.
module rgbmip_ram
  import rgbmip_pkg::*;
#(
  parameter int WIDTH = LINE_W,
  parameter int DEPTH = DEFAULT_MAX_OUT_SIDE,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write to the same entry returns the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

/* rtl/rgb555_mipmap_box_downsample_core.sv */
// Top level of the 2x2 box filter mip level generator for RGB555 streams.
// The input beat that completes a block is registered in stage one, then its result in the result register.
// Throughput: one source pixel per cycle while the result stream takes results, set by the single line store port pair.
// The line store needs no clearing pass, so the block is ready right after reset.
// Reset (rst, synchronous, active high) zeroes the position, the pipeline valids and
// sets out_side to 256; the line store contents are left as they are.
module rgb555_mipmap_box_downsample_core
  import rgbmip_pkg::*;
#(
  parameter int MAX_OUT_SIDE = DEFAULT_MAX_OUT_SIDE
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: output side length in pixels.
  input  logic                  cfg_wr_en,
  input  logic [OUT_SIDE_W-1:0] cfg_wr_data,
  // Source stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SRC_DATA_W-1:0] s_axis_tdata,   // [15:0] src_pixel
  input  logic                  s_axis_tuser,   // [0] image_start
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [14:0] mip_pixel, [15] zero
  output logic                  m_axis_tlast    // image_done
);

  // Width of the clamped side, of source coordinates with headroom, of stored
  // coordinates and of the line store address.
  localparam int SIDE_W = $clog2(MAX_OUT_SIDE + 1);
  localparam int SW1    = SIDE_W + 1;
  localparam int POS_W  = $clog2(2 * MAX_OUT_SIDE);
  localparam int AW     = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int CW     = (SIDE_W > OUT_SIDE_W) ? SIDE_W : OUT_SIDE_W;

  // Registers.
  logic [OUT_SIDE_W-1:0] out_side;
  logic [POS_W-1:0]      src_column;
  logic [POS_W-1:0]      src_row;
  logic [PIXEL_W-1:0]    left_pixel;

  // Pipeline stage one holds the accepted beat with its resolved position.
  logic                  s1_valid;
  logic [PIXEL_W-1:0]    s1_pixel;
  logic [PIXEL_W-1:0]    s1_left;
  logic                  s1_col_odd;
  logic                  s1_row_odd;
  logic [AW-1:0]         s1_slot;
  logic                  s1_last;

  // Result register.
  logic                  m_valid;
  logic [PIXEL_W-1:0]    m_pixel;
  logic                  m_last;

  // Combinational signals.
  logic [CW-1:0]         side_ext;
  logic [CW-1:0]         side_sel;
  logic [SIDE_W-1:0]     side;
  logic [SW1-1:0]        src_side;
  logic [SW1-1:0]        col_a;
  logic [SW1-1:0]        row_a;
  logic [SW1-1:0]        col_b;
  logic [SW1-1:0]        row_b;
  logic [SW1-1:0]        row_c;
  logic [SW1-1:0]        col_inc;
  logic [SW1-1:0]        row_inc;
  logic [SW1-1:0]        src_column_next;
  logic [SW1-1:0]        src_row_next;
  logic [AW-1:0]         slot;
  logic                  pos_last;
  logic                  accept;
  logic                  s1_emit;
  logic                  s1_store;
  logic                  s1_move;
  logic                  out_free;
  logic                  ram_we;
  logic                  ram_re;
  logic [LINE_W-1:0]     ram_rdata;

  // The configured side is clamped to 1..MAX_OUT_SIDE; the source is twice that.
  always_comb begin
    side_ext = CW'(out_side);
    if (side_ext == '0) begin
      side_sel = CW'(1);
    end else if (side_ext > CW'(MAX_OUT_SIDE)) begin
      side_sel = CW'(MAX_OUT_SIDE);
    end else begin
      side_sel = side_ext;
    end
    side     = SIDE_W'(side_sel);
    src_side = {side, 1'b0};
  end

  // Position of the incoming beat. A start flag forces the origin, and a stored
  // position that lies outside the current source size wraps first, which only
  // matters after the side was changed in the middle of an image.
  always_comb begin
    col_a = s_axis_tuser ? '0 : SW1'(src_column);
    row_a = s_axis_tuser ? '0 : SW1'(src_row);
    if (col_a >= src_side) begin
      col_b = '0;
      row_b = row_a + SW1'(1);
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
    row_c    = (row_b >= src_side) ? '0 : row_b;
    slot     = col_b[AW:1];
    pos_last = (row_c == src_side - SW1'(1)) && (col_b == src_side - SW1'(1));

    // Advance in raster order with wrap at the end of the image.
    col_inc = col_b + SW1'(1);
    row_inc = row_c + SW1'(1);
    if (col_inc >= src_side) begin
      src_column_next = '0;
      src_row_next    = (row_inc >= src_side) ? '0 : row_inc;
    end else begin
      src_column_next = col_inc;
      src_row_next    = row_c;
    end
  end

  // Handshake. Stage one drains into the result register, or retires at once
  // when its beat only writes the line store or only latches a left pixel.
  assign s1_emit       = s1_col_odd && s1_row_odd;
  assign s1_store      = s1_col_odd && !s1_row_odd;
  assign out_free      = !m_valid || m_axis_tready;
  assign s1_move       = s1_valid && (!s1_emit || out_free);
  assign s_axis_tready = !s1_valid || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The top pair of a block is fetched with the even-column beat of the lower
  // row, so the data waits in the RAM output register for the odd-column beat.
  // The last write of the upper row can land on the same edge; the RAM then
  // forwards the written data.
  assign ram_we = s1_move && s1_store;
  assign ram_re = accept && row_c[0] && !col_b[0];

  rgbmip_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_OUT_SIDE)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot),
    .wdata (pair_sum(s1_left, s1_pixel)),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_side <= OUT_SIDE_RESET;
    end else if (cfg_wr_en) begin
      out_side <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_column <= '0;
      src_row    <= '0;
      left_pixel <= '0;
    end else if (accept) begin
      src_column <= src_column_next[POS_W-1:0];
      src_row    <= src_row_next[POS_W-1:0];
      if (!col_b[0]) begin
        left_pixel <= s_axis_tdata[PIXEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel   <= s_axis_tdata[PIXEL_W-1:0];
      s1_left    <= left_pixel;
      s1_col_odd <= col_b[0];
      s1_row_odd <= row_c[0];
      s1_slot    <= slot;
      s1_last    <= pos_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_move && s1_emit) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      m_pixel <= avg_pixel(ram_rdata, pair_sum(s1_left, s1_pixel));
      m_last  <= s1_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {1'b0, m_pixel};
  assign m_axis_tlast  = m_last;

`include "rgb555_mipmap_box_downsample_core_assert.svh"

  // The last source pixel of an image always closes a block.
  `RGBMIP_ASSERT(a_last_closes_block, s1_valid && s1_last |-> s1_emit)
  // A new result only appears after stage one handed over a block.
  `RGBMIP_ASSERT(a_result_from_stage, m_valid && !$past(m_valid) |-> $past(s1_move && s1_emit))
  // A start beat lands at column zero, so it never closes a block.
  `RGBMIP_ASSERT(a_start_even_column, accept && s_axis_tuser |=> s1_valid && !s1_col_odd)
  // Reset leaves both pipeline stages empty.
  `RGBMIP_ASSERT_ALWAYS(a_reset_empty, rst |=> !s1_valid && !m_valid)

endmodule
